// ===== design/paint_pixel_blender_assert.svh =====
// ----------------------------------------------------------------------------
// Paint pixel blender assertion macros
// Shared property forms for the blender's concurrent checks. Each macro
// samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAINT_PIXEL_BLENDER_ASSERT_SVH
`define PAINT_PIXEL_BLENDER_ASSERT_SVH

// Same-cycle implication
`define PPB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ppb_pkg.sv =====
// ----------------------------------------------------------------------------
// Paint pixel blender package
// Word types, blend mode codes and the default queue depth shared by the
// front end, the back end and the top level.
// ----------------------------------------------------------------------------
package ppb_pkg;

    // Blend mode codes
    localparam logic [1:0] MODE_MIX      = 2'd0;
    localparam logic [1:0] MODE_BRIGHTEN = 2'd1;
    localparam logic [1:0] MODE_DARKEN   = 2'd2;
    localparam logic [1:0] MODE_ERASE    = 2'd3;

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Input word: paint pixel and canvas pixel
    typedef struct packed {
        logic [7:0] paint_red;
        logic [7:0] paint_green;
        logic [7:0] paint_blue;
        logic [7:0] paint_alpha;
        logic [7:0] canvas_red;
        logic [7:0] canvas_green;
        logic [7:0] canvas_blue;
        logic [7:0] canvas_alpha;
    } pix_word_t;

    // Output word: blended pixel
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } res_word_t;

    // Classified job handed from front to back
    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] weight;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] alpha;
        logic [1:0] mode;
        logic       use_last;
    } job_t;

endpackage

// ===== design/ppb_front.sv =====
// ----------------------------------------------------------------------------
// Paint pixel blender front end
// Accepts input words, works out the output alpha and whether the stored
// colour replaces the canvas colour, and queues the resulting jobs.
// ----------------------------------------------------------------------------
module ppb_front #(
    parameter int DEPTH = ppb_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        mode,
    input  logic              pix_valid,
    output logic              pix_ready,
    input  ppb_pkg::pix_word_t pix,
    output logic              job_valid,
    input  logic              job_pop,
    output ppb_pkg::job_t     job
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ppb_pkg::job_t  q_mem [DEPTH];
    ppb_pkg::job_t  job_in;
    logic [IW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [8:0]     alpha_sum;
    logic           push;
    logic           pop;

    // Classify the incoming word
    always_comb
    begin
        alpha_sum          = {1'b0, pix.paint_alpha} + {1'b0, pix.canvas_alpha};
        job_in.src_red     = pix.paint_red;
        job_in.src_green   = pix.paint_green;
        job_in.src_blue    = pix.paint_blue;
        job_in.weight      = pix.paint_alpha;
        job_in.dst_red     = pix.canvas_red;
        job_in.dst_green   = pix.canvas_green;
        job_in.dst_blue    = pix.canvas_blue;
        job_in.mode        = mode;
        if (mode == ppb_pkg::MODE_ERASE)
        begin
            job_in.use_last = 1'b0;
            job_in.alpha    = (pix.canvas_alpha < pix.paint_alpha) ? 8'd0
                            : pix.canvas_alpha - pix.paint_alpha;
        end
        else
        begin
            job_in.use_last = (pix.canvas_alpha == 8'd0);
            job_in.alpha    = alpha_sum[8] ? 8'd255 : alpha_sum[7:0];
        end
    end

    // Queue handshake
    assign pix_ready = (count_reg != CW'(DEPTH));
    assign push      = pix_valid && pix_ready;
    assign job_valid = (count_reg != '0);
    assign pop       = job_pop && job_valid;
    assign job       = q_mem[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the job word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= job_in;
        end
    end

endmodule

// ===== design/ppb_back.sv =====
// ----------------------------------------------------------------------------
// Paint pixel blender back end
// Takes one job at a time and passes its three colour channels in turn
// through a shared multiply and divide-by-255 pipeline, keeps the colour of
// the last result and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module ppb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_pop,
    input  ppb_pkg::job_t      job,
    output logic               res_valid,
    input  logic               res_ready,
    output ppb_pkg::res_word_t res
);

    `include "paint_pixel_blender_assert.svh"

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Truncating divide by 255 for values below 2^24: estimate by shifts,
    // then correct the remainder with at most three subtractions
    function automatic logic [16:0] div255(input logic [23:0] x);
        logic [16:0] est;
        logic [24:0] prod;
        logic [9:0]  rem;
        est  = {1'b0, x[23:8]} + {9'b0, x[23:16]};
        prod = {est, 8'b0} - {8'b0, est};
        rem  = 10'({1'b0, x} - prod);
        for (int i = 0; i < 3; i++)
        begin
            if (rem >= 10'd255)
            begin
                rem = rem - 10'd255;
                est = est + 17'd1;
            end
        end
        return est;
    endfunction

    logic [1:0]         state_reg, state_next;
    logic [1:0]         cnt_reg, cnt_next;
    ppb_pkg::job_t      cur_reg;
    logic [7:0]         last_red_reg, last_green_reg, last_blue_reg;
    logic               res_valid_reg, res_valid_next;
    ppb_pkg::res_word_t res_reg;

    logic               v1_reg, v2_reg, v3_reg;
    logic [1:0]         ch1_reg, ch2_reg, ch3_reg;
    logic [15:0]        m1_reg, m2_1_reg, m2_2_reg, m2_3_reg;
    logic [23:0]        t2_reg;
    logic [15:0]        u3_reg;

    logic               darken, erase;
    logic [7:0]         s_sel, d_raw, last_sel, d_sel, w_sel, mul_b;
    logic [15:0]        m1_a, m2_a;
    logic [23:0]        t_b;
    logic [16:0]        q_c;
    logic [15:0]        u_c;
    logic [16:0]        sum_d, q_d;
    logic [7:0]         v_d;
    logic               final_d;

    assign darken = (cur_reg.mode == ppb_pkg::MODE_DARKEN);
    assign erase  = (cur_reg.mode == ppb_pkg::MODE_ERASE);

    // Pick the channel to issue
    always_comb
    begin
        unique case (cnt_reg)
            CH_RED:
            begin
                s_sel    = cur_reg.src_red;
                d_raw    = cur_reg.dst_red;
                last_sel = last_red_reg;
            end
            CH_GREEN:
            begin
                s_sel    = cur_reg.src_green;
                d_raw    = cur_reg.dst_green;
                last_sel = last_green_reg;
            end
            CH_BLUE:
            begin
                s_sel    = cur_reg.src_blue;
                d_raw    = cur_reg.dst_blue;
                last_sel = last_blue_reg;
            end
            default:
            begin
                s_sel    = 8'd0;
                d_raw    = 8'd0;
                last_sel = 8'd0;
            end
        endcase
    end

    // Stage one: source and canvas products
    always_comb
    begin
        d_sel = cur_reg.use_last ? last_sel : d_raw;
        w_sel = (cur_reg.mode == ppb_pkg::MODE_MIX || darken)
              ? 8'd255 - cur_reg.weight : 8'd255;
        mul_b = darken ? d_sel : cur_reg.weight;
        m1_a  = erase ? 16'd0 : {8'd0, s_sel} * {8'd0, mul_b};
        m2_a  = {8'd0, d_sel} * {8'd0, w_sel};
    end

    // Stage two: weight the multiply term in darken
    assign t_b = darken ? {8'd0, m1_reg} * {16'd0, cur_reg.weight} : {8'd0, m1_reg};

    // Stage three: first divide in darken
    assign q_c = div255(t2_reg);
    assign u_c = darken ? q_c[15:0] : t2_reg[15:0];

    // Final stage: sum, divide and saturate
    always_comb
    begin
        sum_d   = {1'b0, u3_reg} + {1'b0, m2_3_reg};
        q_d     = div255({7'd0, sum_d});
        v_d     = (q_d > 17'd255) ? 8'd255 : q_d[7:0];
        final_d = v3_reg && (ch3_reg == CH_BLUE);
    end

    // Sequencer
    assign job_pop = (state_reg == ST_IDLE) && job_valid && (!res_valid_reg || res_ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_pop)
                begin
                    state_next = ST_ISSUE;
                    cnt_next   = CH_RED;
                end
            end
            ST_ISSUE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CH_BLUE)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (final_d)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (final_d)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= CH_RED;
            res_valid_reg  <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            last_red_reg   <= 8'd0;
            last_green_reg <= 8'd0;
            last_blue_reg  <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            v1_reg        <= (state_reg == ST_ISSUE);
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            if (v3_reg)
            begin
                unique case (ch3_reg)
                    CH_RED:   last_red_reg   <= v_d;
                    CH_GREEN: last_green_reg <= v_d;
                    CH_BLUE:  last_blue_reg  <= v_d;
                    default:  last_red_reg   <= last_red_reg;
                endcase
            end
        end
    end

    // Advance the channel pipeline and capture the job
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cur_reg <= job;
        end
        ch1_reg  <= cnt_reg;
        m1_reg   <= m1_a;
        m2_1_reg <= m2_a;
        ch2_reg  <= ch1_reg;
        t2_reg   <= t_b;
        m2_2_reg <= m2_1_reg;
        ch3_reg  <= ch2_reg;
        u3_reg   <= u_c;
        m2_3_reg <= m2_2_reg;
        if (v3_reg)
        begin
            unique case (ch3_reg)
                CH_RED:   res_reg.out_red   <= v_d;
                CH_GREEN: res_reg.out_green <= v_d;
                CH_BLUE:
                begin
                    res_reg.out_blue  <= v_d;
                    res_reg.out_alpha <= cur_reg.alpha;
                end
                default:  res_reg.out_red   <= res_reg.out_red;
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Checks
    `PPB_ASSERT_NOW(a_idle_drained, state_reg == ST_IDLE, !(v1_reg || v2_reg || v3_reg), "channel in flight while idle")
    `PPB_ASSERT_NOW(a_issue_out_free, state_reg == ST_ISSUE, !res_valid_reg, "result word still held while issuing")
    `PPB_ASSERT_NOW(a_final_out_free, final_d, !res_valid_reg, "last channel lands on a held result word")
    `PPB_ASSERT_NEXT(a_final_shown, final_d, res_valid_reg && state_reg == ST_IDLE, "finished item not shown")

endmodule

// ===== design/paint_pixel_blender.sv =====
// ----------------------------------------------------------------------------
// Paint pixel blender
// Blends a paint pixel into a canvas pixel in one of four modes.
// ----------------------------------------------------------------------------
// One word in gives one blended word out, in order. The three colour
// channels are issued one per cycle into a single multiply and
// divide-by-255 pipeline, and the next item starts only once the blue
// channel has left it, because an item with an empty canvas reads the
// colour of the one before. Up to QUEUE_DEPTH words are accepted ahead
// while the back end is busy or the result waits. The blend mode register
// may be written only while the block is idle; its value is sampled when a
// word is accepted.
module paint_pixel_blender #(
    parameter int QUEUE_DEPTH = ppb_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_data,
    input  logic               pix_valid,
    output logic               pix_ready,
    input  ppb_pkg::pix_word_t pix,
    output logic               res_valid,
    input  logic               res_ready,
    output ppb_pkg::res_word_t res
);

    logic [1:0]    mode_reg;
    logic          job_valid;
    logic          job_pop;
    ppb_pkg::job_t job;

    // Blend mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ppb_pkg::MODE_MIX;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    ppb_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job)
    );

    ppb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

// ===== tb/paint_pixel_blender_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paint pixel blender testbench
// Drives paint and canvas words through the blender in every blend mode, runs
// its own blend predictor at each accepted input word, and compares each
// output word field by field in order. Both sides idle in random bursts, the
// receiver holds off for a long stretch once, and the mode register is
// rewritten between phases while the blender is idle.
// ----------------------------------------------------------------------------
module paint_pixel_blender_tb;
    import ppb_pkg::*;

    localparam int          LONG_STALL     = 150;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          PHASE_WORDS    = 235;
    localparam int          IDLE_PCT       = 10;
    localparam int unsigned FULL_SCALE     = 255;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [1:0] cfg_data = MODE_MIX;
    logic      pix_valid = 1'b0;
    logic      pix_ready;
    pix_word_t pix       = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    res_word_t res;

    // Words waiting to be sent, and blended words still owed by the block
    pix_word_t  pending_words[$];
    res_word_t  blended_words[$];

    // Predictor state: mode copy and colour of the previous blended word
    logic [1:0] mode_copy  = MODE_MIX;
    logic [7:0] prev_red   = 8'd0;
    logic [7:0] prev_green = 8'd0;
    logic [7:0] prev_blue  = 8'd0;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int send_gap       = 0;
    int recv_gap       = 0;
    int stall_requests = 0;
    int stall_served   = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    paint_pixel_blender DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [1:0] mode_of(input int idx);
        case (idx)
            0:       return MODE_MIX;
            1:       return MODE_BRIGHTEN;
            2:       return MODE_DARKEN;
            default: return MODE_ERASE;
        endcase
    endfunction

    // One colour channel of the blend modes; every divide truncates
    function automatic logic [7:0] blend_channel_value(input logic [1:0] mode,
                                                       input logic [7:0] s,
                                                       input logic [7:0] d,
                                                       input logic [7:0] a);
        int unsigned sv;
        int unsigned dv;
        int unsigned av;
        int unsigned v;
        sv = {24'd0, s};
        dv = {24'd0, d};
        av = {24'd0, a};
        case (mode)
            MODE_MIX:
            begin
                v = (sv * av + dv * (FULL_SCALE - av)) / FULL_SCALE;
            end
            MODE_BRIGHTEN:
            begin
                v = (sv * av + dv * FULL_SCALE) / FULL_SCALE;
                if (v > FULL_SCALE)
                    v = FULL_SCALE;
            end
            default:
            begin
                v = ((sv * dv * av) / FULL_SCALE + dv * (FULL_SCALE - av)) / FULL_SCALE;
            end
        endcase
        return v[7:0];
    endfunction

    // Work out the blended word for an accepted input word and queue it
    task automatic predict_blend(input pix_word_t w);
        res_word_t   r;
        logic [7:0]  dst_r;
        logic [7:0]  dst_g;
        logic [7:0]  dst_b;
        int unsigned alpha_sum;
        if (mode_copy == MODE_ERASE)
        begin
            r.out_red   = w.canvas_red;
            r.out_green = w.canvas_green;
            r.out_blue  = w.canvas_blue;
            r.out_alpha = (w.canvas_alpha < w.paint_alpha) ? 8'd0
                                                           : w.canvas_alpha - w.paint_alpha;
        end
        else
        begin
            // An empty canvas takes the colour of the previous word
            dst_r = (w.canvas_alpha == 8'd0) ? prev_red   : w.canvas_red;
            dst_g = (w.canvas_alpha == 8'd0) ? prev_green : w.canvas_green;
            dst_b = (w.canvas_alpha == 8'd0) ? prev_blue  : w.canvas_blue;
            r.out_red   = blend_channel_value(mode_copy, w.paint_red,   dst_r, w.paint_alpha);
            r.out_green = blend_channel_value(mode_copy, w.paint_green, dst_g, w.paint_alpha);
            r.out_blue  = blend_channel_value(mode_copy, w.paint_blue,  dst_b, w.paint_alpha);
            alpha_sum   = {24'd0, w.paint_alpha} + {24'd0, w.canvas_alpha};
            r.out_alpha = (alpha_sum > FULL_SCALE) ? 8'd255 : alpha_sum[7:0];
        end
        prev_red   = r.out_red;
        prev_green = r.out_green;
        prev_blue  = r.out_blue;
        blended_words.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_blended(input res_word_t got);
        res_word_t want;
        if (blended_words.size() == 0)
        begin
            report_mismatch($sformatf("output word %h with none expected", got));
        end
        else
        begin
            want = blended_words.pop_front();
            if (got.out_red !== want.out_red)
                report_mismatch($sformatf("out_red got %0d want %0d",
                                          got.out_red, want.out_red));
            if (got.out_green !== want.out_green)
                report_mismatch($sformatf("out_green got %0d want %0d",
                                          got.out_green, want.out_green));
            if (got.out_blue !== want.out_blue)
                report_mismatch($sformatf("out_blue got %0d want %0d",
                                          got.out_blue, want.out_blue));
            if (got.out_alpha !== want.out_alpha)
                report_mismatch($sformatf("out_alpha got %0d want %0d",
                                          got.out_alpha, want.out_alpha));
        end
    endtask

    function automatic pix_word_t make_word(input logic [7:0] pr, input logic [7:0] pg,
                                            input logic [7:0] pb, input logic [7:0] pa,
                                            input logic [7:0] cr, input logic [7:0] cg,
                                            input logic [7:0] cb, input logic [7:0] ca);
        pix_word_t w;
        w.paint_red    = pr;
        w.paint_green  = pg;
        w.paint_blue   = pb;
        w.paint_alpha  = pa;
        w.canvas_red   = cr;
        w.canvas_green = cg;
        w.canvas_blue  = cb;
        w.canvas_alpha = ca;
        return w;
    endfunction

    // Byte with a bias towards the ends of the range
    function automatic logic [7:0] pick_level(input int zero_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < zero_pct)
            return 8'd0;
        else if (roll < zero_pct + 10)
            return 8'd255;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic pix_word_t random_word();
        return make_word(pick_level(10), pick_level(10), pick_level(10), pick_level(10),
                         pick_level(10), pick_level(10), pick_level(10), pick_level(25));
    endfunction

    // Wait until every word is sent and every blended word has come back
    task automatic await_idle();
        @(negedge clk);
        while (pending_words.size() != 0 || pix_valid || blended_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_data  <= m;
        mode_copy  = m;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Sender: present the next word once the current one is taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_valid <= 1'b0;
            pix       <= '0;
        end
        else
        begin
            if (pix_valid && pix_ready)
                predict_blend(pix);
            if (!pix_valid || pix_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pix_valid <= 1'b0;
                end
                else if (pending_words.size() != 0 && send_idle_pct > 0
                         && $urandom_range(0, 99) < send_idle_pct)
                begin
                    send_gap   = $urandom_range(1, 16) - 1;
                    pix_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    pix       <= pending_words.pop_front();
                    pix_valid <= 1'b1;
                end
                else
                begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each taken word, then decide whether to hold off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
                check_blended(res);
            if (stall_served != stall_requests)
            begin
                stall_served = stall_requests;
                recv_gap     = LONG_STALL;
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                res_ready <= 1'b0;
            end
            else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                recv_gap   = $urandom_range(1, 16) - 1;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && pix_ready) || (res_valid && res_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** paint_pixel_blender: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int         p;
        int         n;
        logic [1:0] m;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset mode with black as the stored colour, then full and empty words
        @(negedge clk);
        pending_words.push_back(make_word(200, 100, 50, 128, 9, 9, 9, 0));
        pending_words.push_back(make_word(255, 255, 255, 255, 255, 255, 255, 255));
        pending_words.push_back(make_word(0, 0, 0, 0, 0, 0, 0, 0));
        await_idle();

        // Directed words in each mode: saturation, zero and full weight,
        // empty canvas, and erase below zero
        for (p = 0; p < 4; p++)
        begin
            write_mode(mode_of(p));
            @(negedge clk);
            pending_words.push_back(make_word(255, 255, 255, 255, 255, 255, 255, 255));
            pending_words.push_back(make_word(255, 255, 255, 0, 10, 20, 30, 255));
            pending_words.push_back(make_word(1, 2, 3, 255, 200, 150, 100, 1));
            pending_words.push_back(make_word(90, 180, 45, 77, 7, 7, 7, 0));
            pending_words.push_back(make_word(0, 0, 0, 200, 255, 128, 64, 100));
            await_idle();
        end

        // Random phases, one mode each
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            m = (p < 4) ? mode_of(3 - p) : mode_of($urandom_range(0, 3));
            write_mode(m);
            @(negedge clk);
            if (p == RANDOM_PHASES - 1 || p % 3 == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = IDLE_PCT;
                recv_idle_pct = IDLE_PCT;
            end
            // Hold the receiver off so the block fills and stalls its input
            if (p == 1)
                stall_requests++;
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                // Let the block drain completely halfway through
                if (p == 2 && n == PHASE_WORDS / 2)
                    await_idle();
                pending_words.push_back(random_word());
            end
            await_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** paint_pixel_blender: PASSED **");
        else
            $display("** paint_pixel_blender: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ppb_pkg.sv
design/ppb_front.sv
design/ppb_back.sv
design/paint_pixel_blender.sv
tb/paint_pixel_blender_tb.sv
